[src/modular_exponentiation_top_assert.svh]
// Assertion macros for the modular exponentiation block.
// Used by modular_exponentiation_top; expects a clock clk and a reset rst in scope.
`ifndef MODULAR_EXPONENTIATION_TOP_ASSERT_SVH
`define MODULAR_EXPONENTIATION_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define ME_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define ME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/modexp_pkg.sv]
// Shared types and constants for the modular exponentiation block.
// No dependencies; used by modular_exponentiation_top.
`default_nettype none

package modexp_pkg;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,  // waiting for a transaction
    ST_REDA = 6'b000010,  // reduce the base mod m
    ST_REDS = 6'b000100,  // reduce the seed mod m
    ST_NEXT = 6'b001000,  // pick the next operation for the exponent bit
    ST_MDBL = 6'b010000,  // multiply: double the accumulator mod m
    ST_MADD = 6'b100000   // multiply: add the multiplicand mod m
  } state_t;

  // Exponents below this are answered directly
  localparam int unsigned EXP_DIRECT_LIMIT = 3;

endpackage

`default_nettype wire

[src/modular_exponentiation_top.sv]
// Modular exponentiation top level: sequencer plus one shared add/compare/subtract unit.
// Depends on modexp_pkg and modular_exponentiation_top_assert.svh.
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   -----------------------------
//   input     base, exponent, base_squared_mod        start high while busy is low
//   output    result                                  done high for one cycle
//   config    cfg_data                                cfg_we high at a clock edge
//
// Exponent 0, 1 or 2: the result is registered at the edge that takes the transaction.
// Otherwise the sequencer reduces base and seed, then for each lower exponent bit runs a
// squaring (none for the bit just below the top) and, for a one bit, a multiply, each on
// the shared modular add unit, with sequencing steps in between.
// Synchronous reset sets modulus to 1 and idles the sequencer; the receiver cannot stall.
`default_nettype none

module modular_exponentiation_top #(
  parameter int unsigned WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [WIDTH-1:0] base,
  input  wire logic [WIDTH-1:0] exponent,
  input  wire logic [WIDTH-1:0] base_squared_mod,
  output logic                  done,
  output logic [WIDTH-1:0]      result,
  input  wire logic             cfg_we,
  input  wire logic [WIDTH-1:0] cfg_data
);

  localparam int unsigned CNT_W = $clog2(WIDTH);

  modexp_pkg::state_t state;

  logic [WIDTH-1:0] m;         // modulus
  logic [WIDTH-1:0] abar;      // base reduced mod m
  logic [WIDTH-1:0] v;         // partial result
  logic [WIDTH-1:0] r;         // accumulator of the shared unit
  logic [WIDTH-1:0] sh;        // serial operand, consumed from the MSB
  logic [WIDTH-1:0] e;         // exponent, normalized to its top bit
  logic [CNT_W-1:0] cnt;       // bit count within one pass
  logic [CNT_W-1:0] top;       // exponent bits still to process
  logic             sq_done;
  logic             mul_done;
  logic             use_base;

  logic             take;          // transaction accepted this cycle
  logic             direct;        // exponent answered without the datapath
  logic             in_mult;       // inside a modular multiply
  logic             mdbl_or_next;  // legal successors of a modular add

  // Shared unit: (ua + ub + cin) with one conditional subtract of m
  logic [WIDTH-1:0] ua;
  logic [WIDTH-1:0] ub;
  logic             ucin;
  logic [WIDTH:0]   usum;
  logic [WIDTH-1:0] udiff;
  logic [WIDTH-1:0] uout;

  always_comb begin
    ua   = r;
    ub   = r;
    ucin = 1'b0;
    case (state)
      modexp_pkg::ST_REDA, modexp_pkg::ST_REDS: begin
        ucin = sh[WIDTH-1];
      end
      modexp_pkg::ST_MADD: begin
        ub = use_base ? abar : v;
      end
      default: begin
        ucin = 1'b0;
      end
    endcase
    usum  = {1'b0, ua} + {1'b0, ub} + {{WIDTH{1'b0}}, ucin};
    udiff = usum[WIDTH-1:0] - m;
    uout  = (usum >= {1'b0, m}) ? udiff : usum[WIDTH-1:0];
  end

  assign busy         = (state != modexp_pkg::ST_IDLE);
  assign take         = start && !busy;
  assign direct       = (exponent < WIDTH'(modexp_pkg::EXP_DIRECT_LIMIT));
  assign in_mult      = (state == modexp_pkg::ST_MDBL) || (state == modexp_pkg::ST_MADD);
  assign mdbl_or_next = (state == modexp_pkg::ST_MDBL) || (state == modexp_pkg::ST_NEXT);

  // Strobe the result for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (take && direct) || ((state == modexp_pkg::ST_NEXT) && (top == '0));
    end
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= modexp_pkg::ST_IDLE;
      m     <= WIDTH'(1);
    end else begin
      if (cfg_we) begin
        m <= cfg_data;
      end
      case (state)
        modexp_pkg::ST_IDLE: begin
          if (start) begin
            e   <= exponent;
            sh  <= base;
            v   <= base_squared_mod;
            r   <= '0;
            cnt <= CNT_W'(WIDTH - 1);
            top <= CNT_W'(WIDTH - 1);
            if (exponent == '0) begin
              result <= WIDTH'(1);
            end else if (exponent == WIDTH'(1)) begin
              result <= base;
            end else if (exponent == WIDTH'(2)) begin
              result <= base_squared_mod;
            end else begin
              state <= modexp_pkg::ST_REDA;
            end
          end
        end
        // Reduce the base; normalize the exponent meanwhile
        modexp_pkg::ST_REDA: begin
          if (!e[WIDTH-1]) begin
            e   <= e << 1;
            top <= top - 1'b1;
          end
          if (cnt == '0) begin
            abar  <= uout;
            sh    <= v;
            r     <= '0;
            cnt   <= CNT_W'(WIDTH - 1);
            state <= modexp_pkg::ST_REDS;
          end else begin
            r   <= uout;
            sh  <= sh << 1;
            cnt <= cnt - 1'b1;
          end
        end
        // Reduce the seed; drop the top exponent bit it stands for
        modexp_pkg::ST_REDS: begin
          r  <= uout;
          sh <= sh << 1;
          if (cnt == '0) begin
            v        <= uout;
            e        <= e << 1;
            sq_done  <= 1'b1;
            mul_done <= 1'b0;
            state    <= modexp_pkg::ST_NEXT;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        // Finish, square, multiply, or advance to the next exponent bit
        modexp_pkg::ST_NEXT: begin
          if (top == '0) begin
            result <= v;
            state  <= modexp_pkg::ST_IDLE;
          end else if (!sq_done) begin
            sq_done  <= 1'b1;
            use_base <= 1'b0;
            r        <= '0;
            sh       <= v;
            cnt      <= CNT_W'(WIDTH - 1);
            state    <= modexp_pkg::ST_MDBL;
          end else if (e[WIDTH-1] && !mul_done) begin
            mul_done <= 1'b1;
            use_base <= 1'b1;
            r        <= '0;
            sh       <= v;
            cnt      <= CNT_W'(WIDTH - 1);
            state    <= modexp_pkg::ST_MDBL;
          end else begin
            e        <= e << 1;
            top      <= top - 1'b1;
            sq_done  <= 1'b0;
            mul_done <= 1'b0;
          end
        end
        // Double the accumulator; add the multiplicand on a one bit
        modexp_pkg::ST_MDBL: begin
          r <= uout;
          if (sh[WIDTH-1]) begin
            state <= modexp_pkg::ST_MADD;
          end else begin
            sh <= sh << 1;
            if (cnt == '0) begin
              v     <= uout;
              state <= modexp_pkg::ST_NEXT;
            end else begin
              cnt <= cnt - 1'b1;
            end
          end
        end
        modexp_pkg::ST_MADD: begin
          r  <= uout;
          sh <= sh << 1;
          if (cnt == '0) begin
            v     <= uout;
            state <= modexp_pkg::ST_NEXT;
          end else begin
            cnt   <= cnt - 1'b1;
            state <= modexp_pkg::ST_MDBL;
          end
        end
        default: begin
          state <= modexp_pkg::ST_IDLE;
        end
      endcase
    end
  end

`include "modular_exponentiation_top_assert.svh"

  `ME_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while sequencer busy")
  `ME_ASSERT_NEXT(a_long_start, take && !direct, state == modexp_pkg::ST_REDA, "no base reduction")
  `ME_ASSERT_NOW(a_exp_norm, state == modexp_pkg::ST_REDS, e[WIDTH-1], "exponent not normalized")
  `ME_ASSERT_NEXT(a_madd_follow, state == modexp_pkg::ST_MADD, mdbl_or_next, "bad step after add")
  `ME_ASSERT_NOW(a_acc_reduced, in_mult, (r < m) || (m == '0), "accumulator not reduced mod m")

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for modular_exponentiation_top: square-and-multiply power mod m.
// Depends only on the RTL under src/. A queue-fed driver, a result monitor and an in-bench
// power predictor compare every result against the power predicted from base, seed and exponent mod m.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned WIDTH       = 64;
  localparam int unsigned STALL_LIMIT = 100_000;
  localparam logic [WIDTH-1:0] ALL_ONES = {WIDTH{1'b1}};

  typedef struct packed {
    logic [WIDTH-1:0] base;
    logic [WIDTH-1:0] exponent;
    logic [WIDTH-1:0] seed;
  } power_req_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [WIDTH-1:0] base = '0;
  logic [WIDTH-1:0] exponent = '0;
  logic [WIDTH-1:0] base_squared_mod = '0;
  logic             cfg_we = 1'b0;
  logic [WIDTH-1:0] cfg_data = '0;
  logic             busy;
  logic             done;
  logic [WIDTH-1:0] result;

  power_req_t       pending_reqs[$];
  logic [WIDTH-1:0] powers_due[$];
  power_req_t       taken_req;
  logic [WIDTH-1:0] modulus_copy = WIDTH'(1);
  int               idle_pct = 0;
  int               fail_count = 0;
  int               reqs_taken = 0;
  int               powers_checked = 0;
  int               modulus_settings = 1;
  int               stall_cycles = 0;

  modular_exponentiation_top #(.WIDTH(WIDTH)) DUT (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .base             (base),
    .exponent         (exponent),
    .base_squared_mod (base_squared_mod),
    .done             (done),
    .result           (result),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // x*y mod m at full double width; a zero modulus leaves the low word
  function automatic logic [WIDTH-1:0] mod_mul(logic [WIDTH-1:0] x, logic [WIDTH-1:0] y,
                                               logic [WIDTH-1:0] m);
    logic [2*WIDTH-1:0] prod;
    logic [2*WIDTH-1:0] rem;
    prod = {{WIDTH{1'b0}}, x} * {{WIDTH{1'b0}}, y};
    if (m == '0) return prod[WIDTH-1:0];
    rem = prod % {{WIDTH{1'b0}}, m};
    return rem[WIDTH-1:0];
  endfunction

  // Walk the exponent from its top bit; the seed stands for the leading "10"
  function automatic logic [WIDTH-1:0] mod_power(power_req_t req, logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] acc;
    int top;
    int i;
    if (req.exponent == 0) return WIDTH'(1);
    if (req.exponent == 1) return req.base;
    if (req.exponent == 2) return req.seed;
    top = WIDTH - 1;
    while (!req.exponent[top]) top--;
    acc = req.seed;
    if (req.exponent[top-1]) acc = mod_mul(acc, req.base, m);
    for (i = top - 2; i >= 0; i--) begin
      acc = mod_mul(acc, acc, m);
      if (req.exponent[i]) acc = mod_mul(acc, req.base, m);
    end
    return acc;
  endfunction

  function automatic logic [WIDTH-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Driver: hold each transaction until taken, then launch the next or idle
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        taken_req = pending_reqs.pop_front();
        powers_due.push_back(mod_power(taken_req, modulus_copy));
        reqs_taken++;
      end
      if (!start || !busy) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
          start            <= 1'b1;
          base             <= pending_reqs[0].base;
          exponent         <= pending_reqs[0].exponent;
          base_squared_mod <= pending_reqs[0].seed;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (powers_due.size() == 0) begin
        $error("result %h arrived with no transaction outstanding", result);
        fail_count++;
      end else begin
        if (result !== powers_due[0]) begin
          $error("result mismatch: expected %h, actual %h", powers_due[0], result);
          fail_count++;
        end
        void'(powers_due.pop_front());
        powers_checked++;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no transaction or result for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Hold off until every transaction is taken and every result is back
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || powers_due.size() != 0 || start || busy)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_modulus(logic [WIDTH-1:0] value);
    wait_drained();
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    modulus_copy = value;
    modulus_settings++;
  endtask

  task automatic add_req(logic [WIDTH-1:0] b, logic [WIDTH-1:0] e, logic [WIDTH-1:0] s);
    power_req_t req;
    req.base     = b;
    req.exponent = e;
    req.seed     = s;
    pending_reqs.push_back(req);
  endtask

  // Mostly short exponents with a true seed; a few direct and full-width ones and junk seeds
  task automatic add_random(int count);
    logic [WIDTH-1:0] b;
    logic [WIDTH-1:0] e;
    logic [WIDTH-1:0] s;
    int pick;
    int nbits;
    repeat (count) begin
      pick = $urandom_range(99);
      b = (pick < 5) ? '0 : (pick < 10) ? ALL_ONES : rand_word();
      pick = $urandom_range(99);
      if (pick < 8) begin
        e = WIDTH'($urandom_range(2));
      end else if (pick < 14) begin
        e = rand_word();
        e[WIDTH-1] = 1'b1;
      end else begin
        nbits = $urandom_range(2, 14);
        e = rand_word() & ((64'd1 << nbits) - 64'd1);
        e[nbits-1] = 1'b1;
      end
      s = ($urandom_range(99) < 80) ? mod_mul(b, b, modulus_copy) : rand_word();
      add_req(b, e, s);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset modulus of one: direct answers stay unreduced, products collapse to zero
    idle_pct = 38;
    add_req(64'd5, 64'd0, rand_word());
    add_req(ALL_ONES, 64'd1, 64'd3);
    add_req(64'd9, 64'd2, ALL_ONES);
    add_req(64'd7, 64'd3, 64'd49);

    // Largest 64-bit prime: field extremes and an unreduced seed
    write_modulus(64'hFFFF_FFFF_FFFF_FFC5);
    add_req(64'd0, 64'd5, 64'd0);
    add_req(ALL_ONES, 64'd3, mod_mul(ALL_ONES, ALL_ONES, modulus_copy));
    add_req(64'd3, ALL_ONES, 64'd9);
    add_req(64'd2, 64'h8000_0000_0000_0000, 64'd4);
    add_req(64'd12345, 64'd10, ALL_ONES);
    add_req(ALL_ONES, 64'd1, 64'd0);
    add_req(rand_word(), 64'd2, rand_word());
    add_req(64'd0, 64'd0, 64'd0);

    // Zero modulus: every product keeps its low word
    write_modulus('0);
    add_req(rand_word(), 64'd5, rand_word());
    add_req(ALL_ONES, 64'd7, ALL_ONES);
    add_req(rand_word(), 64'd3, rand_word());
    add_random(13);

    write_modulus(64'd97);
    add_random(13);

    // Sender idles heavily from here
    write_modulus(64'h8000_0000_0000_001D);
    idle_pct = 87;
    add_random(13);

    write_modulus(ALL_ONES);
    add_random(13);

    write_modulus(rand_word() | 64'h8000_0000_0000_0000);
    add_random(13);

    // Back to back from here
    write_modulus(64'd2);
    idle_pct = 0;
    add_random(13);

    write_modulus({48'd0, 16'($urandom_range(3, 65535))});
    add_random(13);

    wait_drained();
    repeat (20) @(posedge clk);

    $display("Checked %0d of %0d power transactions across %0d modulus settings",
             powers_checked, reqs_taken, modulus_settings);
    $display("Covered zero, one, two and all-ones moduli, direct exponents and full-width ones");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
